// File: design/mlt_pkg.sv
// Shared types and constants of the MAC learning table.
// Used by the controller, the datapath and the top level.
package mlt_pkg;

	typedef enum logic [2:0] {
		MODE_LEARN  = 3'd0,
		MODE_LOOKUP = 3'd1,
		MODE_TICK   = 3'd2,
		MODE_AGE    = 3'd3,
		MODE_FLUSH  = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_SPOOF   = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		REG_AGEING  = 2'd0,
		REG_FWD     = 2'd1,
		REG_TOPO    = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_BREAD,
		S_BDEC,
		S_SREAD,
		S_SDEC,
		S_DONE
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic wipe;      // clear one valid row after reset
		logic capture;   // latch request fields
		logic bread;     // issue bucket read
		logic bdecide;   // resolve learn / lookup
		logic sread;     // issue sweep read
		logic sdecide;   // resolve one sweep entry
		logic tick;      // advance time base
		logic clear;     // start of request: clear counters
		logic finish;    // drive result strobe
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic sweep_last;
	} stat_t;

	localparam int unsigned REMOVED_W = 11;
	localparam logic [REMOVED_W-1:0] REMOVED_MAX = '1;

endpackage

// File: design/mlt_ctrl.sv
// Controller state machine of the MAC learning table.
// Depends on mlt_pkg.
module mlt_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [2:0]       mode,
	input  mlt_pkg::stat_t   stat,
	output logic             busy,
	output mlt_pkg::cmd_t    cmd
);

	mlt_pkg::state_t state_q, state_n;
	logic [2:0] mode_q;

	// Hold state and the request mode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mlt_pkg::S_INIT;
			mode_q  <= '0;
		end else begin
			state_q <= state_n;
			if (start && state_q == mlt_pkg::S_IDLE) mode_q <= mode;
		end
	end

	// Next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			mlt_pkg::S_INIT:  state_n = stat.sweep_last ? mlt_pkg::S_IDLE : mlt_pkg::S_INIT;
			mlt_pkg::S_IDLE: begin
				if (start) begin
					if (mode == mlt_pkg::MODE_LEARN || mode == mlt_pkg::MODE_LOOKUP)
						state_n = mlt_pkg::S_BREAD;
					else if (mode == mlt_pkg::MODE_AGE || mode == mlt_pkg::MODE_FLUSH)
						state_n = mlt_pkg::S_SREAD;
					else
						state_n = mlt_pkg::S_DONE;
				end
			end
			mlt_pkg::S_BREAD: state_n = mlt_pkg::S_BDEC;
			mlt_pkg::S_BDEC:  state_n = mlt_pkg::S_DONE;
			mlt_pkg::S_SREAD: state_n = mlt_pkg::S_SDEC;
			mlt_pkg::S_SDEC:  state_n = stat.sweep_last ? mlt_pkg::S_DONE : mlt_pkg::S_SREAD;
			mlt_pkg::S_DONE:  state_n = mlt_pkg::S_IDLE;
			default:          state_n = mlt_pkg::S_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd = '0;
		busy = 1'b1;
		unique case (state_q)
			mlt_pkg::S_INIT:  cmd.wipe = 1'b1;
			mlt_pkg::S_IDLE: begin
				busy = 1'b0;
				cmd.capture = start;
				cmd.clear = start;
			end
			mlt_pkg::S_BREAD: cmd.bread = 1'b1;
			mlt_pkg::S_BDEC:  cmd.bdecide = 1'b1;
			mlt_pkg::S_SREAD: cmd.sread = 1'b1;
			mlt_pkg::S_SDEC:  cmd.sdecide = 1'b1;
			mlt_pkg::S_DONE: begin
				cmd.finish = 1'b1;
				cmd.tick = (mode_q == mlt_pkg::MODE_TICK);
			end
			default: ;
		endcase
	end

endmodule

// File: design/mlt_datapath.sv
// Datapath of the MAC learning table: bucket memory, valid bits, hash,
// match, expiry and sweep logic. Depends on mlt_pkg.
module mlt_datapath #(
	parameter int unsigned HASH_BITS = 8,
	parameter int unsigned WAYS      = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mlt_pkg::cmd_t     cmd,
	output mlt_pkg::stat_t    stat,
	input  logic [2:0]        mode,
	input  logic [47:0]       mac_address,
	input  logic [7:0]        port,
	input  logic              learn_local,
	input  logic [31:0]       hold,
	output logic [1:0]        status,
	output logic              hit,
	output logic [7:0]        out_port,
	output logic              out_local,
	output logic [mlt_pkg::REMOVED_W-1:0] removed
);
	localparam int unsigned NB  = 1 << HASH_BITS;
	localparam int unsigned WB  = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int unsigned EW  = 48 + 8 + 1 + 32;
	localparam int unsigned KW  = $clog2(WAYS + 1);

	typedef logic [EW-1:0] ent_t;

	// One bucket row per address, ways side by side
	logic [WAYS*EW-1:0] mem [NB];
	logic [WAYS-1:0]    vmem [NB];
	logic [WAYS*EW-1:0] rd_q;
	logic [WAYS-1:0]    vrd_q;

	logic [2:0]  mode_q;
	logic [47:0] mac_q;
	logic [7:0]  port_q;
	logic        local_q;
	logic [31:0] now_q;
	logic [HASH_BITS-1:0] sidx_q;
	logic [mlt_pkg::REMOVED_W-1:0] removed_q;
	logic [1:0] status_q;
	logic hit_q, olocal_q;
	logic [7:0] oport_q;

	// Hash of the six bytes
	logic [HASH_BITS-1:0] hash;
	always_comb begin
		logic [31:0] x;
		x = {24'd0, mac_q[47:40]};
		for (int k = 1; k < 6; k++)
			x = (x << 2) ^ {24'd0, mac_q[47-8*k -: 8]};
		x = x ^ (x >> 8);
		hash = x[HASH_BITS-1:0];
	end

	logic [HASH_BITS-1:0] raddr;
	assign raddr = cmd.sread ? sidx_q : hash;

	// Per-way decode of the registered row
	logic [WAYS-1:0] match, expd, killw, freew;
	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			ent_t e;
			logic [31:0] d;
			e = rd_q[w*EW +: EW];
			d = e[31:0] + hold - now_q;
			expd[w]  = !e[32] && (d == 32'd0 || d[31]);
			match[w] = vrd_q[w] && e[EW-1 -: 48] == mac_q;
			freew[w] = !vrd_q[w];
			killw[w] = vrd_q[w] && ((mode_q == mlt_pkg::MODE_AGE) ? expd[w]
			           : (e[40:33] == port_q));
		end
	end

	logic mfound, ffound;
	logic [WB-1:0] mway, fway;
	always_comb begin
		mfound = 1'b0; ffound = 1'b0; mway = '0; fway = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (match[w]) begin mfound = 1'b1; mway = WB'(w); end
			if (freew[w]) begin ffound = 1'b1; fway = WB'(w); end
		end
	end

	ent_t msel;
	assign msel = rd_q[mway*EW +: EW];

	logic [WAYS-1:0] fbit;
	assign fbit = WAYS'(1) << fway;

	logic [KW-1:0] nkill;
	always_comb begin
		nkill = '0;
		for (int w = 0; w < WAYS; w++) nkill = nkill + KW'(killw[w]);
	end

	logic [mlt_pkg::REMOVED_W:0] rsum;
	assign rsum = {1'b0, removed_q} + (mlt_pkg::REMOVED_W+1)'(nkill);

	logic bad_addr;
	assign bad_addr = mac_q == 48'd0 || mac_q[40];

	// Learn decision
	logic wr_en, new_en;
	logic [WB-1:0] wr_way;
	logic [1:0] lstat;
	always_comb begin
		wr_en = 1'b0; new_en = 1'b0; wr_way = mway; lstat = mlt_pkg::ST_OK;
		if (bad_addr) lstat = mlt_pkg::ST_INVALID;
		else if (mfound) begin
			if (msel[32]) lstat = local_q ? mlt_pkg::ST_OK : mlt_pkg::ST_SPOOF;
			else wr_en = 1'b1;
		end else if (ffound) begin
			wr_en = 1'b1; new_en = 1'b1; wr_way = fway;
		end else lstat = mlt_pkg::ST_FULL;
	end

	// Memory read and write; valid rows are cleared by a pass after reset
	always_ff @(posedge clk) begin
		if (cmd.bread || cmd.sread) begin
			rd_q  <= mem[raddr];
			vrd_q <= vmem[raddr];
		end
		if (cmd.bdecide && mode_q == mlt_pkg::MODE_LEARN && wr_en)
			mem[hash][wr_way*EW +: EW] <= {mac_q, port_q, local_q, now_q};
		if (cmd.wipe)
			vmem[sidx_q] <= '0;
		else if (cmd.bdecide && mode_q == mlt_pkg::MODE_LEARN && new_en)
			vmem[hash] <= vrd_q | fbit;
		else if (cmd.sdecide)
			vmem[sidx_q] <= vrd_q & ~killw;
	end

	// Row index, counters, time base
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q <= '0;
			sidx_q <= '0;
			removed_q <= '0;
		end else begin
			if (cmd.clear) begin
				sidx_q <= '0;
				removed_q <= '0;
			end
			if (cmd.tick) now_q <= now_q + 32'd1;
			if (cmd.wipe || cmd.sdecide) sidx_q <= sidx_q + 1'b1;
			if (cmd.sdecide)
				removed_q <= rsum[mlt_pkg::REMOVED_W] ? mlt_pkg::REMOVED_MAX
				             : rsum[mlt_pkg::REMOVED_W-1:0];
		end
	end

	// Capture request and hold results
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= mode; mac_q <= mac_address; port_q <= port; local_q <= learn_local;
			status_q <= mlt_pkg::ST_OK; hit_q <= 1'b0; oport_q <= '0; olocal_q <= 1'b0;
		end
		if (cmd.bdecide) begin
			if (mode_q == mlt_pkg::MODE_LEARN) status_q <= lstat;
			else if (mfound && !expd[mway]) begin
				hit_q <= 1'b1; oport_q <= msel[40:33]; olocal_q <= msel[32];
			end
		end
	end

	assign stat.sweep_last = &sidx_q;
	assign status    = status_q;
	assign hit       = hit_q;
	assign out_port  = oport_q;
	assign out_local = olocal_q;
	assign removed   = removed_q;

	logic unused;
	assign unused = ^{expd, msel[EW-1:41]};

endmodule

// File: design/mac_learning_table.sv
// Top level of the MAC learning table: config registers, controller,
// datapath. Depends on mlt_pkg, mlt_ctrl and mlt_datapath.
//
// A request is taken when start is high and busy low; its result shows
// for one cycle with done and cannot be stalled. After reset busy stays
// high while a clearing pass empties every bucket. Learn and lookup read
// one bucket row, decide and write back, then give the result. Tick and
// unused modes go straight to the result. Age sweep and flush port walk
// every bucket row, with a read and a decide per row.
module mac_learning_table #(
	parameter int unsigned HASH_BITS = 8,
	parameter int unsigned WAYS      = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  mode,
	input  logic [47:0] mac_address,
	input  logic [7:0]  port,
	input  logic        learn_local,
	output logic        done,
	output logic [1:0]  status,
	output logic        hit,
	output logic [7:0]  out_port,
	output logic        out_local,
	output logic [10:0] removed,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	mlt_pkg::cmd_t  cmd;
	mlt_pkg::stat_t stat;
	logic [31:0] ageing_q, fwd_q;
	logic        topo_q;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ageing_q <= 32'd300;
			fwd_q    <= 32'd15;
			topo_q   <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				mlt_pkg::REG_AGEING: ageing_q <= cfg_data;
				mlt_pkg::REG_FWD:    fwd_q <= cfg_data;
				mlt_pkg::REG_TOPO:   topo_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	mlt_ctrl u_ctrl (
		.clk, .arst_n, .start, .mode, .stat, .busy, .cmd
	);

	// Removed count is cleared at every request, so only a sweep leaves it nonzero
	mlt_datapath #(.HASH_BITS(HASH_BITS), .WAYS(WAYS)) u_dp (
		.clk, .arst_n, .cmd, .stat, .mode, .mac_address, .port, .learn_local,
		.hold(topo_q ? fwd_q : ageing_q),
		.status, .hit, .out_port, .out_local, .removed
	);

	assign done = cmd.finish;

	// A result is only strobed while busy
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n) done |-> busy)
		else $error("result strobe outside a request");
	// Busy falls right after the result strobe
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n) done |=> !busy)
		else $error("busy held after result");
	// A taken request raises busy
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("request not taken");

endmodule
